/* design/chte_pkg.sv */
// shared types, codes and defaults of the chained hash table engine
package chte_pkg;

  localparam int MAX_BUCKETS_DEF = 256;
  localparam int POOL_SLOTS_DEF = 1024;
  localparam int KEY_W = 64;
  localparam int SLOT_W = 10;
  localparam int CFG_W = 9;

  typedef enum logic [1:0] {
    REQ_LOOKUP  = 2'd0,
    REQ_REMOVE  = 2'd1,
    REQ_CREATE  = 2'd2,
    REQ_RELEASE = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_CREATED   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_RELEASED  = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] release_slot;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

  typedef struct packed {
    logic              rd;
    logic              pop;
    logic              push;
    logic [SLOT_W-1:0] push_slot;
  } free_ctl_t;

endpackage

/* design/chte_mod.sv */
// iterative remainder unit, eight dividend bits per cycle
module chte_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [chte_pkg::KEY_W-1:0]    dividend_i,
  input  logic [chte_pkg::CFG_W-1:0]    divisor_i,
  output logic                          done_o,
  output logic [chte_pkg::CFG_W-1:0]    rem_o
);

  localparam int STEP = 8;
  localparam int ITER = chte_pkg::KEY_W / STEP;
  localparam int CNT_W = $clog2(ITER);

  logic                       busy_q;
  logic                       done_q;
  logic [CNT_W-1:0]           cnt_q;
  logic [chte_pkg::KEY_W-1:0] dvd_q;
  logic [chte_pkg::CFG_W-1:0] dvs_q;
  logic [chte_pkg::CFG_W-1:0] rem_q, rem_d;

  always_comb begin
    logic [chte_pkg::CFG_W:0] r;
    r = {1'b0, rem_q};
    for (int i = 0; i < STEP; i++) begin
      r = {r[chte_pkg::CFG_W-1:0], dvd_q[chte_pkg::KEY_W-1-i]};
      if (r >= {1'b0, dvs_q}) begin
        r = r - {1'b0, dvs_q};
      end
    end
    rem_d = r[chte_pkg::CFG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ITER - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_q << STEP;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

/* design/chte_free.sv */
// free slot stack memory with its count and low-water mark
module chte_free #(
  parameter int POOL_SLOTS = chte_pkg::POOL_SLOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  chte_pkg::free_ctl_t   ctl_i,
  output logic                  empty_o,
  output logic                  full_o,
  output logic [(POOL_SLOTS > 1 ? $clog2(POOL_SLOTS) : 1)-1:0] slot_o
);

  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int CW = $clog2(POOL_SLOTS + 1);

  logic [SW-1:0] stack_mem [POOL_SLOTS];
  logic [CW-1:0] count_q;
  logic [CW-1:0] lo_q;
  logic [CW-1:0] top_idx;
  logic [SW-1:0] rdata_q;
  logic [SW-1:0] idx_q;
  logic          fresh_q;

  assign top_idx = count_q - 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CW'(POOL_SLOTS);
      lo_q    <= CW'(POOL_SLOTS);
      fresh_q <= 1'b0;
    end else begin
      if (ctl_i.rd) begin
        fresh_q <= (count_q <= lo_q);
      end
      if (ctl_i.pop) begin
        count_q <= top_idx;
        if (top_idx < lo_q) begin
          lo_q <= top_idx;
        end
      end else if (ctl_i.push) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      stack_mem[count_q[SW-1:0]] <= SW'(ctl_i.push_slot);
    end
    if (ctl_i.rd) begin
      rdata_q <= stack_mem[top_idx[SW-1:0]];
      idx_q   <= top_idx[SW-1:0];
    end
  end

  // entries never written read as their own index
  assign slot_o  = fresh_q ? idx_q : rdata_q;
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q >= CW'(POOL_SLOTS));

endmodule

/* design/chained_hash_table_engine_core.sv */
// chained hash table engine top level: heads, entry memory and request sequencer
//
// Requests arrive as one beat on in_valid_i / in_stall_o and each gives exactly
// one result beat on out_valid_o / out_stall_i. One request is worked on at a
// time; in_stall_o stays high from acceptance until the result is loaded into
// the output register, so the next request can be taken while that result waits.
// A release passes through S_REL and S_RESP before its result is loaded into the
// output register. Other requests run the key through the remainder unit (key
// modulo bucket count, eight bits a cycle), read the bucket head, visit each chain
// node through the entry memory with an S_CHECK and an S_NODE step, settle the
// result in S_RESP, and for a create pop a free slot in S_POP before that.
// The bucket count register is written through cfg_we_i / cfg_wdata_i; the user
// must write it only while idle, the block does not enforce this.
// Reset empties all buckets through per-bucket valid bits, refills the free stack
// through a low-water mark, and needs no clearing pass; requests are taken at once.
// While out_stall_i is high the result beat holds and the next result waits.
module chained_hash_table_engine_core #(
  parameter int MAX_BUCKETS = chte_pkg::MAX_BUCKETS_DEF,
  parameter int POOL_SLOTS  = chte_pkg::POOL_SLOTS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [chte_pkg::CFG_W-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  chte_pkg::req_t             in_req_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output chte_pkg::rsp_t             out_rsp_o
);

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int LW = $clog2(POOL_SLOTS + 1);
  localparam int CW = $clog2(POOL_SLOTS + 1);
  localparam int EW = chte_pkg::KEY_W + LW;
  localparam int CFG_RST = (MAX_BUCKETS < 256) ? MAX_BUCKETS : 256;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_MOD   = 8'b00000010,
    S_HEAD  = 8'b00000100,
    S_CHECK = 8'b00001000,
    S_NODE  = 8'b00010000,
    S_POP   = 8'b00100000,
    S_REL   = 8'b01000000,
    S_RESP  = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  logic [chte_pkg::CFG_W-1:0] cfg_q;
  logic [chte_pkg::CFG_W-1:0] nb;
  chte_pkg::req_t             req_q;
  chte_pkg::rsp_t             res_q, res_d;
  chte_pkg::rsp_t             out_q;
  logic                       out_valid_q;
  logic                       in_acc;

  logic          mod_start;
  logic          mod_done;
  logic [chte_pkg::CFG_W-1:0] mod_rem;

  logic [BW-1:0] bucket_q, bucket_d;
  logic [LW-1:0] head_q, head_d;
  logic [LW-1:0] cur_q, cur_d;
  logic [LW-1:0] prev_q, prev_d;
  logic [chte_pkg::KEY_W-1:0] prev_key_q, prev_key_d;
  logic [CW-1:0] steps_q, steps_d;

  logic [LW-1:0] head_mem [MAX_BUCKETS];
  logic [MAX_BUCKETS-1:0] head_vld_q;
  logic [LW-1:0] head_rdata_q;
  logic          head_rvld_q;
  logic [BW-1:0] head_raddr;
  logic          head_we;
  logic [LW-1:0] head_wdata;

  logic [EW-1:0] ent_mem [POOL_SLOTS];
  logic [EW-1:0] ent_rdata_q;
  logic          ent_we;
  logic [SW-1:0] ent_waddr;
  logic [EW-1:0] ent_wdata;
  logic [chte_pkg::KEY_W-1:0] ent_key;
  logic [LW-1:0] ent_link;

  chte_pkg::free_ctl_t free_ctl;
  logic          free_empty;
  logic          free_full;
  logic [SW-1:0] free_slot;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign ent_key    = ent_rdata_q[EW-1:LW];
  assign ent_link   = ent_rdata_q[LW-1:0];
  assign head_raddr = BW'(mod_rem);

  always_comb begin
    if (cfg_q == '0) begin
      nb = chte_pkg::CFG_W'(1);
    end else if (32'(cfg_q) > MAX_BUCKETS) begin
      nb = chte_pkg::CFG_W'(MAX_BUCKETS);
    end else begin
      nb = cfg_q;
    end
  end

  assign mod_start = in_acc && (in_req_i.req_type != chte_pkg::REQ_RELEASE);

  chte_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (in_req_i.key),
    .divisor_i  (nb),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  chte_free #(
    .POOL_SLOTS (POOL_SLOTS)
  ) u_free (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (free_ctl),
    .empty_o (free_empty),
    .full_o  (free_full),
    .slot_o  (free_slot)
  );

  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    bucket_d   = bucket_q;
    head_d     = head_q;
    cur_d      = cur_q;
    prev_d     = prev_q;
    prev_key_d = prev_key_q;
    steps_d    = steps_q;
    head_we    = 1'b0;
    head_wdata = ent_link;
    ent_we     = 1'b0;
    ent_waddr  = SW'(prev_q);
    ent_wdata  = {prev_key_q, ent_link};
    free_ctl   = '0;
    free_ctl.push_slot = req_q.release_slot;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (in_req_i.req_type == chte_pkg::REQ_RELEASE) ? S_REL : S_MOD;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          bucket_d = head_raddr;
          state_d  = S_HEAD;
        end
      end
      S_HEAD: begin
        head_d  = head_rvld_q ? head_rdata_q : LW'(POOL_SLOTS);
        cur_d   = head_d;
        prev_d  = LW'(POOL_SLOTS);
        steps_d = '0;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (cur_q >= LW'(POOL_SLOTS) || steps_q >= CW'(POOL_SLOTS)) begin
          res_d = '{status: chte_pkg::ST_NOT_FOUND, slot: '0};
          state_d = S_RESP;
          if (req_q.req_type == chte_pkg::REQ_CREATE) begin
            if (free_empty) begin
              res_d.status = chte_pkg::ST_EXHAUSTED;
            end else begin
              free_ctl.rd = 1'b1;
              state_d = S_POP;
            end
          end
        end else begin
          state_d = S_NODE;
        end
      end
      S_NODE: begin
        if (ent_key == req_q.key) begin
          res_d = '{status: chte_pkg::ST_FOUND, slot: chte_pkg::SLOT_W'(cur_q)};
          state_d = S_RESP;
          if (req_q.req_type == chte_pkg::REQ_REMOVE) begin
            if (prev_q >= LW'(POOL_SLOTS)) begin
              head_we = 1'b1;
            end else begin
              ent_we = 1'b1;
            end
          end
        end else begin
          prev_d     = cur_q;
          prev_key_d = ent_key;
          cur_d      = ent_link;
          steps_d    = steps_q + 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_POP: begin
        free_ctl.pop = 1'b1;
        state_d = S_RESP;
        if (32'(free_slot) >= POOL_SLOTS) begin
          res_d = '{status: chte_pkg::ST_EXHAUSTED, slot: '0};
        end else begin
          ent_we     = 1'b1;
          ent_waddr  = free_slot;
          ent_wdata  = {req_q.key, head_q};
          head_we    = 1'b1;
          head_wdata = LW'(free_slot);
          res_d = '{status: chte_pkg::ST_CREATED, slot: chte_pkg::SLOT_W'(free_slot)};
        end
      end
      S_REL: begin
        state_d = S_RESP;
        if (32'(req_q.release_slot) >= POOL_SLOTS || free_full) begin
          res_d = '{status: chte_pkg::ST_NOT_FOUND, slot: req_q.release_slot};
        end else begin
          free_ctl.push = 1'b1;
          res_d = '{status: chte_pkg::ST_RELEASED, slot: req_q.release_slot};
        end
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cfg_q       <= chte_pkg::CFG_W'(CFG_RST);
      out_valid_q <= 1'b0;
      head_vld_q  <= '0;
      head_rvld_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_rvld_q <= head_vld_q[head_raddr];
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      if (head_we) begin
        head_vld_q[bucket_q] <= 1'b1;
      end
      if (state_q == S_RESP && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= in_req_i;
    end
    res_q      <= res_d;
    bucket_q   <= bucket_d;
    head_q     <= head_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    prev_key_q <= prev_key_d;
    steps_q    <= steps_d;
    if (state_q == S_RESP && (!out_valid_q || !out_stall_i)) begin
      out_q <= res_q;
    end
  end

  // bucket head memory
  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[bucket_q] <= head_wdata;
    end
    head_rdata_q <= head_mem[head_raddr];
  end

  // entry memory, key and link of each slot
  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata_q <= ent_mem[SW'(cur_q)];
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> in_stall_o)
    else $error("accepted beat did not make the block busy");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == S_RESP))
    else $error("result beat appeared without a finished request");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_rsp_o.status <= chte_pkg::ST_RELEASED))
    else $error("result status code out of range");

  a_free_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_ctl.pop |-> !free_empty) and (free_ctl.push |-> !free_full))
    else $error("free stack overflow or underflow");
`endif

endmodule
